// ===== src/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W     = 16;
   localparam int NUM_W      = 7;
   localparam int INT_W      = 22;
   localparam int UNS_W      = 23;
   localparam int SUM_W      = SIZE_W + CNT_W;
   localparam int FREE_W     = ((SUM_W > UNS_W) ? SUM_W : UNS_W) + 1;

   localparam logic [INT_W-1:0] INT_MAXV = {INT_W{1'b1}};
   localparam logic [UNS_W-1:0] UNS_MAXV = {UNS_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_REPORT = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } st_type;

   typedef struct packed {
      op_type              opcode;
      logic [SIZE_W-1:0]   size;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [NUM_W-1:0]    block_number;
      logic                table_full;
      logic [INT_W-1:0]    internal_frag;
      logic [INT_W-1:0]    external_frag;
   } rsp_type;

   typedef struct packed {
      logic                used;
      logic [SIZE_W-1:0]   size;
   } ram_word_type;

   localparam int WORD_W = $bits(ram_word_type);

   typedef struct packed {
      logic                start;
      logic                beat;
      logic [IDX_W-1:0]    idx;
      logic [SIZE_W-1:0]   size;
   } scan_ctl_type;

   typedef struct packed {
      logic                found;
      logic                any_free;
      logic [IDX_W-1:0]    best_idx;
      logic [SIZE_W-1:0]   best_size;
      logic [SUM_W-1:0]    free_sum;
   } scan_res_type;

   function automatic logic [NUM_W-1:0] blk_num(input logic [CNT_W-1:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[NUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/best_fit_block_allocator.sv =====
`default_nettype none

// Channel  Direction  Payload   Accepted when
// req      in         req_type  req_valid && !req_stall
// rsp      out        rsp_type  rsp_valid && !rsp_stall
//
// Load and clear: the request goes from idle to the response state, and the result is registered there.
// Allocate and report: the scan state makes one block-table read per cycle
// on the RAM read port for each of the count loaded blocks, then the drain
// and response states follow; an empty table goes straight to response.
// One request is in flight at a time; req_stall is high until its result
// enters the output register, which waits while rsp_stall holds it.
// Reset needs no clearing pass: the table is read only below the count.
module best_fit_block_allocator (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bfa_pkg::req_type    req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output bfa_pkg::rsp_type         rsp_data
);
   import bfa_pkg::*;

   scan_ctl_type     scan_ctl;
   scan_res_type     scan_res;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   ram_word_type     wr_data;
   ram_word_type     rd_word;

   bfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   bfa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .req_size (scan_ctl.size),
      .word     (rd_word),
      .res      (scan_res)
   );

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .scan_ctl  (scan_ctl),
      .scan_res  (scan_res),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("table write during scan read");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new request taken while one is in flight");

   a_grant_numbered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted) |->
         ((rsp_data.block_number != '0) && !rsp_data.table_full))
      else $error("grant without block number");

   a_scan_quiet_on_start: assert property (@(posedge clock) disable iff (reset)
      scan_ctl.start |-> (!scan_ctl.beat && !rd_en))
      else $error("scan start overlaps a read beat");

endmodule

`default_nettype wire

// ===== src/bfa_ram.sv =====
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bfa_scan.sv =====
`default_nettype none

module bfa_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bfa_pkg::scan_ctl_type       ctl,
   input  wire logic [bfa_pkg::SIZE_W-1:0]  req_size,
   input  wire bfa_pkg::ram_word_type       word,
   output bfa_pkg::scan_res_type            res
);
   import bfa_pkg::*;

   logic              found_ff, found_in;
   logic              any_free_ff, any_free_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [SUM_W-1:0]  free_sum_ff, free_sum_in;

   always_comb begin
      found_in     = found_ff;
      any_free_in  = any_free_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      free_sum_in  = free_sum_ff;
      if (ctl.start) begin
         found_in    = 1'b0;
         any_free_in = 1'b0;
         free_sum_in = '0;
      end else if (ctl.beat && !word.used) begin
         any_free_in = 1'b1;
         free_sum_in = free_sum_ff + SUM_W'(word.size);
         if ((req_size <= word.size) && (!found_ff || (word.size < best_size_ff))) begin
            found_in     = 1'b1;
            best_idx_in  = ctl.idx;
            best_size_in = word.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         any_free_ff <= 1'b0;
         free_sum_ff <= '0;
      end else begin
         found_ff    <= found_in;
         any_free_ff <= any_free_in;
         free_sum_ff <= free_sum_in;
      end
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   always_comb begin
      res.found     = found_ff;
      res.any_free  = any_free_ff;
      res.best_idx  = best_idx_ff;
      res.best_size = best_size_ff;
      res.free_sum  = free_sum_ff;
   end

endmodule

`default_nettype wire

// ===== src/bfa_ctrl.sv =====
`default_nettype none

module bfa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire bfa_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output bfa_pkg::rsp_type                 rsp_data,
   output bfa_pkg::scan_ctl_type            scan_ctl,
   input  wire bfa_pkg::scan_res_type       scan_res,
   output logic                             rd_en,
   output logic [bfa_pkg::IDX_W-1:0]        rd_addr,
   output logic                             wr_en,
   output logic [bfa_pkg::IDX_W-1:0]        wr_addr,
   output bfa_pkg::ram_word_type            wr_data
);
   import bfa_pkg::*;

   st_type            state_ff, state_in;
   op_type            op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [INT_W-1:0]  internal_ff, internal_in;
   logic [UNS_W-1:0]  unserved_ff, unserved_in;
   logic              any_uns_ff, any_uns_in;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic              beat_ff, beat_in;
   logic [IDX_W-1:0]  beat_idx_ff, beat_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              has_room;
   logic [INT_W:0]    int_sum;
   logic [UNS_W:0]    uns_sum;
   logic [FREE_W-1:0] free_mem;
   logic              cond;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign has_room = count_ff < CNT_W'(MAX_BLOCKS);
   assign int_sum  = (INT_W + 1)'(internal_ff)
                   + (INT_W + 1)'(scan_res.best_size - size_ff);
   assign uns_sum  = (UNS_W + 1)'(unserved_ff) + (UNS_W + 1)'(size_ff);
   assign free_mem = FREE_W'(internal_ff) + FREE_W'(scan_res.free_sum);
   assign cond     = any_uns_ff || scan_res.any_free;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      internal_in  = internal_ff;
      unserved_in  = unserved_ff;
      any_uns_in   = any_uns_ff;
      rd_addr_in   = rd_addr_ff;
      beat_in      = 1'b0;
      beat_idx_in  = beat_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = (state_ff != ST_IDLE);
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = IDX_W'(count_ff);
      wr_data      = '{used: 1'b0, size: size_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_data.opcode;
               size_in    = req_data.size;
               rd_addr_in = '0;
               if (((req_data.opcode == OP_ALLOC) || (req_data.opcode == OP_REPORT))
                   && (count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            rd_en       = 1'b1;
            beat_in     = 1'b1;
            beat_idx_in = rd_addr_ff;
            rd_addr_in  = rd_addr_ff + IDX_W'(1);
            if (CNT_W'(rd_addr_ff) == (count_ff - CNT_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_data_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_LOAD: begin
                     if (has_room) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        rsp_data_in.block_number = blk_num(count_ff + CNT_W'(1));
                     end else begin
                        rsp_data_in.table_full = 1'b1;
                     end
                  end
                  OP_ALLOC: begin
                     if (scan_res.found) begin
                        wr_en   = 1'b1;
                        wr_addr = scan_res.best_idx;
                        wr_data = '{used: 1'b1, size: scan_res.best_size};
                        rsp_data_in.granted      = 1'b1;
                        rsp_data_in.block_number =
                           blk_num(CNT_W'(scan_res.best_idx) + CNT_W'(1));
                        internal_in = int_sum[INT_W] ? INT_MAXV : int_sum[INT_W-1:0];
                     end else begin
                        unserved_in = uns_sum[UNS_W] ? UNS_MAXV : uns_sum[UNS_W-1:0];
                        any_uns_in  = 1'b1;
                     end
                  end
                  OP_REPORT: begin
                     if (cond && (FREE_W'(unserved_ff) <= free_mem)) begin
                        rsp_data_in.external_frag = (free_mem > FREE_W'(INT_MAXV))
                                                  ? INT_MAXV : free_mem[INT_W-1:0];
                     end
                  end
                  OP_CLEAR: begin
                     count_in    = '0;
                     internal_in = '0;
                     unserved_in = '0;
                     any_uns_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.internal_frag = internal_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         internal_ff  <= '0;
         unserved_ff  <= '0;
         any_uns_ff   <= 1'b0;
         beat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         internal_ff  <= internal_in;
         unserved_ff  <= unserved_in;
         any_uns_ff   <= any_uns_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      size_ff     <= size_in;
      rd_addr_ff  <= rd_addr_in;
      beat_idx_ff <= beat_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      scan_ctl.start = accept;
      scan_ctl.beat  = beat_ff;
      scan_ctl.idx   = beat_idx_ff;
      scan_ctl.size  = size_ff;
   end

   assign rd_addr   = rd_addr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
